[rtl/i2cm_pkg.sv]
package i2cm_pkg;

    // Width of the acknowledge timeout register and wait counter
    localparam int TIMEOUT_WIDTH = 16;
    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = TIMEOUT_WIDTH'(2000);

    // Payload widths on the stream ports
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    // Raw command codes carried in tuser
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        CK_NONE,
        CK_START,
        CK_STOP,
        CK_WRITE,
        CK_READ
    } cmd_kind_t;

    // One tick as it waits in the queue
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    // One result, in m_tdata order from the lowest bit up (reversed in the struct)
    typedef struct packed {
        logic       nack;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_released;
        logic       sda_out;
        logic       scl;
    } result_t;

endpackage

[rtl/i2cm_front.sv]
module i2cm_front (
    input  logic [i2cm_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic [i2cm_pkg::S_TDATA_W-1:0] s_tdata,
    output i2cm_pkg::tick_t                tick
);
    import i2cm_pkg::*;

    logic       cmd_valid;
    logic [1:0] cmd;

    assign cmd_valid = s_tuser[0];
    assign cmd       = s_tuser[2:1];

    // Classify the offered command and keep the operands of the tick
    always_comb begin
        tick.tx_byte  = s_tdata[7:0];
        tick.send_ack = s_tdata[8];
        tick.sda_in   = s_tdata[9];
        if (!cmd_valid) begin
            tick.kind = CK_NONE;
        end else begin
            case (cmd)
                CMD_START: tick.kind = CK_START;
                CMD_STOP:  tick.kind = CK_STOP;
                CMD_WRITE: tick.kind = CK_WRITE;
                CMD_READ:  tick.kind = CK_READ;
                default:   tick.kind = CK_NONE;
            endcase
        end
    end

endmodule

[rtl/i2cm_queue.sv]
module i2cm_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  i2cm_pkg::tick_t push_data,
    output logic            not_full,
    input  logic            pop,
    output i2cm_pkg::tick_t pop_data,
    output logic            not_empty
);
    import i2cm_pkg::*;

    tick_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Store entries; payload needs no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/i2cm_back.sv]
module i2cm_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [i2cm_pkg::TIMEOUT_WIDTH-1:0]  cfg_timeout,
    input  logic                                q_not_empty,
    input  i2cm_pkg::tick_t                     q_data,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output i2cm_pkg::result_t                   m_result
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST1, PH_ST2, PH_ST3, PH_ST4,
        PH_SP1, PH_SP2, PH_SP3, PH_SP4,
        PH_W0, PH_W1, PH_W2, PH_W3, PH_W4,
        PH_AKP, PH_AKH, PH_AKL, PH_AKT,
        PH_R0, PH_R1, PH_R2, PH_R3,
        PH_RA1, PH_RA2, PH_RA3, PH_RA4
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [2:0]               bit_cnt_reg, bit_cnt_next;
    logic [7:0]               sh_reg, sh_next;
    logic [TIMEOUT_WIDTH-1:0] wait_cnt_reg, wait_cnt_next;
    logic [TIMEOUT_WIDTH-1:0] timeout_reg;
    logic                     ack_choice_reg, ack_choice_next;
    logic                     scl_reg, scl_next;
    logic                     sda_reg, sda_next;
    logic                     dir_in_reg, dir_in_next;
    logic                     nack_reg, nack_next;
    logic [7:0]               rx_reg, rx_next;
    logic                     busy, done;
    logic                     out_valid_reg;
    result_t                  out_reg;
    logic                     advance;

    // Take the next tick when the output slot is free or being drained
    assign advance  = q_not_empty && (!out_valid_reg || m_tready);
    assign q_pop    = advance;
    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    // One step of the pin sequence for the tick at the head of the queue
    always_comb begin
        phase_t ph;
        ph              = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        sh_next         = sh_reg;
        wait_cnt_next   = wait_cnt_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        dir_in_next     = dir_in_reg;
        nack_next       = nack_reg;
        rx_next         = rx_reg;
        done            = 1'b0;

        // Launch a command only from idle; others are dropped
        if (phase_reg == PH_IDLE) begin
            case (q_data.kind)
                CK_START: ph = PH_ST1;
                CK_STOP:  ph = PH_SP1;
                CK_WRITE: begin
                    sh_next   = q_data.tx_byte;
                    nack_next = 1'b0;
                    ph        = PH_W0;
                end
                CK_READ: begin
                    ack_choice_next = q_data.send_ack;
                    ph              = PH_R0;
                end
                default: ph = PH_IDLE;
            endcase
        end

        busy       = (ph != PH_IDLE);
        phase_next = ph;

        case (ph)
            PH_IDLE: phase_next = PH_IDLE;
            PH_ST1: begin dir_in_next = 1'b0; sda_next = 1'b1; phase_next = PH_ST2; end
            PH_ST2: begin scl_next = 1'b1; phase_next = PH_ST3; end
            PH_ST3: begin sda_next = 1'b0; phase_next = PH_ST4; end
            PH_ST4: begin scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1; end
            PH_SP1: begin dir_in_next = 1'b0; scl_next = 1'b0; phase_next = PH_SP2; end
            PH_SP2: begin sda_next = 1'b0; phase_next = PH_SP3; end
            PH_SP3: begin scl_next = 1'b1; phase_next = PH_SP4; end
            PH_SP4: begin sda_next = 1'b1; phase_next = PH_IDLE; done = 1'b1; end
            PH_W0: begin
                dir_in_next  = 1'b0;
                scl_next     = 1'b0;
                bit_cnt_next = 3'd0;
                phase_next   = PH_W1;
            end
            PH_W1: begin
                // Present the MSB and shift it out
                sda_next   = sh_next[7];
                sh_next    = {sh_next[6:0], 1'b0};
                phase_next = PH_W2;
            end
            PH_W2: begin scl_next = 1'b1; phase_next = PH_W3; end
            PH_W3: begin scl_next = 1'b0; phase_next = PH_W4; end
            PH_W4: begin
                if (bit_cnt_reg == 3'd7) begin
                    wait_cnt_next = '0;
                    phase_next    = PH_AKP;
                end else begin
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    phase_next   = PH_W1;
                end
            end
            PH_AKP: begin
                // Poll for the acknowledge; give up into a stop on timeout
                dir_in_next = 1'b1;
                sda_next    = 1'b1;
                scl_next    = 1'b1;
                if (!q_data.sda_in) begin
                    nack_next  = 1'b0;
                    phase_next = PH_AKH;
                end else if (wait_cnt_reg >= timeout_reg) begin
                    nack_next  = 1'b1;
                    phase_next = PH_SP1;
                end else begin
                    wait_cnt_next = wait_cnt_reg + TIMEOUT_WIDTH'(1);
                end
            end
            PH_AKH: phase_next = PH_AKL;
            PH_AKL: begin scl_next = 1'b0; phase_next = PH_AKT; end
            PH_AKT: begin phase_next = PH_IDLE; done = 1'b1; end
            PH_R0: begin
                dir_in_next  = 1'b1;
                sda_next     = 1'b1;
                bit_cnt_next = 3'd0;
                phase_next   = PH_R1;
            end
            PH_R1: begin scl_next = 1'b0; phase_next = PH_R2; end
            PH_R2: begin scl_next = 1'b1; phase_next = PH_R3; end
            PH_R3: begin
                // Sample SDA while SCL is high
                sh_next = {sh_reg[6:0], q_data.sda_in};
                if (bit_cnt_reg == 3'd7) begin
                    phase_next = PH_RA1;
                end else begin
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    phase_next   = PH_R1;
                end
            end
            PH_RA1: begin
                scl_next    = 1'b0;
                dir_in_next = 1'b0;
                rx_next     = sh_reg;
                phase_next  = PH_RA2;
            end
            PH_RA2: begin sda_next = ~ack_choice_reg; phase_next = PH_RA3; end
            PH_RA3: begin scl_next = 1'b1; phase_next = PH_RA4; end
            PH_RA4: begin scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1; end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Hold sequencer state and the registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= 3'd0;
            sh_reg         <= 8'd0;
            wait_cnt_reg   <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            dir_in_reg     <= 1'b0;
            nack_reg       <= 1'b0;
            rx_reg         <= 8'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_timeout;
            end
            if (advance) begin
                phase_reg      <= phase_next;
                bit_cnt_reg    <= bit_cnt_next;
                sh_reg         <= sh_next;
                wait_cnt_reg   <= wait_cnt_next;
                ack_choice_reg <= ack_choice_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                dir_in_reg     <= dir_in_next;
                nack_reg       <= nack_next;
                rx_reg         <= rx_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg.scl          <= scl_next;
            out_reg.sda_out      <= dir_in_next | sda_next;
            out_reg.sda_released <= dir_in_next;
            out_reg.busy_res     <= busy;
            out_reg.done_res     <= done;
            out_reg.rx_byte      <= rx_next;
            out_reg.nack         <= nack_next;
        end
    end

endmodule

[rtl/i2c_master_byte_engine.sv]
// Tick-driven I2C master byte engine.
// s_ channel: one transaction per timing tick. s_tuser carries the command
// strobe and code, s_tdata the byte to send, the ACK choice for a read and the
// sampled SDA level. A command offered while a sequence runs is dropped.
// m_ channel: exactly one transaction per input tick, carrying the SCL and SDA
// drive levels after that tick's step, SDA direction, busy and done flags, the
// last received byte and the NACK flag.
// cfg channel: writes the acknowledge timeout in ticks; write only while idle.
// Path to m_: an accepted tick is first stored in the front queue, and the
// sequencer then takes it from the queue and registers its result for m_.
// Throughput: one tick per cycle while m_tready does not hold the result, set by
// the single-step sequencer that retires one queued tick a cycle.
// Stall: when m_tready is low the result holds, the two-entry queue absorbs
// up to two further ticks, and s_tready drops once it is full.
// Reset: aresetn low clears the queue and returns the bus to idle with SCL and
// SDA high and SDA driven, timeout 2000 ticks, received byte and NACK cleared.
module i2c_master_byte_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] cmd_valid, [2:1] cmd
    input  logic [i2cm_pkg::S_TUSER_W-1:0]      s_tuser,
    // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
    input  logic [i2cm_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scl, [1] sda_out, [2] sda_released, [3] busy_res, [4] done_res,
    // [12:5] rx_byte, [13] nack, [15:14] zero
    output logic [i2cm_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2cm_pkg::TIMEOUT_WIDTH-1:0]  cfg_data
);
    import i2cm_pkg::*;

    tick_t   front_tick;
    tick_t   q_data;
    logic    q_not_full;
    logic    q_not_empty;
    logic    q_pop;
    result_t result;

    assign s_tready  = q_not_full;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {(M_TDATA_W - $bits(result_t))'(0), result};

    i2cm_front u_front (
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .tick    (front_tick)
    );

    i2cm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && q_not_full),
        .push_data (front_tick),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_not_empty)
    );

    i2cm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid),
        .cfg_timeout (cfg_data),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (result)
    );

endmodule

[rtl/i2cm_checker.sv]
module i2cm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [i2cm_pkg::M_TDATA_W-1:0]      m_tdata
);
    import i2cm_pkg::*;

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // A finished command is always a busy tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3])
    else $error("done without busy");

    // A released SDA line is never driven low
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("SDA driven low while released");

    // The queue fills only behind a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tb_i2c_master_byte_engine.sv]
module tb_i2c_master_byte_engine;
    import i2cm_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;

    // Sequencer steps of the bus engine, mirrored for prediction
    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_ST1, SQ_ST2, SQ_ST3, SQ_ST4,
        SQ_SP1, SQ_SP2, SQ_SP3, SQ_SP4,
        SQ_W0, SQ_W1, SQ_W2, SQ_W3, SQ_W4,
        SQ_AKP, SQ_AKH, SQ_AKL, SQ_AKT,
        SQ_R0, SQ_R1, SQ_R2, SQ_R3,
        SQ_RA1, SQ_RA2, SQ_RA3, SQ_RA4
    } seq_phase_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TUSER_W-1:0]     s_tuser = '0;
    logic [S_TDATA_W-1:0]     s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b1;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [TIMEOUT_WIDTH-1:0] cfg_data = '0;

    i2c_master_byte_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predicted engine state
    logic [TIMEOUT_WIDTH-1:0] timeout_m;
    seq_phase_t               ph;
    logic [2:0]               bit_cnt;
    logic [7:0]               shift_m;
    logic [TIMEOUT_WIDTH-1:0] wait_m;
    logic                     ack_sel_m;
    logic                     scl_m;
    logic                     sda_m;
    logic                     nack_m;
    logic                     dir_in_m;
    logic [7:0]               rx_m;

    result_t want_levels[$];
    result_t want;
    result_t got;

    int  errors = 0;
    int  n_ticks = 0;
    int  n_results = 0;
    int  n_cmds[4] = '{0, 0, 0, 0};
    int  n_dropped = 0;
    int  n_timeouts = 0;
    int  n_cfg = 0;
    int  burst_left = 0;
    int  idle_cycles = 0;
    int  rx_run = 0;
    bit  steady = 1'b0;

    task automatic reset_model();
        timeout_m = TIMEOUT_RESET;
        ph        = SQ_IDLE;
        bit_cnt   = '0;
        shift_m   = '0;
        wait_m    = '0;
        ack_sel_m = 1'b0;
        scl_m     = 1'b1;
        sda_m     = 1'b1;
        nack_m    = 1'b0;
        dir_in_m  = 1'b0;
        rx_m      = '0;
    endtask

    // Advance the predicted engine by one tick and return the pin levels after it
    function automatic result_t bus_tick(logic cv, logic [1:0] c, logic [7:0] tx,
                                         logic sa, logic sd);
        result_t r;
        logic    busy;
        logic    done;
        busy = 1'b0;
        done = 1'b0;
        // take a command only when idle; drop it otherwise
        if (ph == SQ_IDLE && cv) begin
            n_cmds[c]++;
            case (c)
                CMD_START: ph = SQ_ST1;
                CMD_STOP:  ph = SQ_SP1;
                CMD_WRITE: begin
                    shift_m = tx;
                    nack_m  = 1'b0;
                    ph      = SQ_W0;
                end
                CMD_READ: begin
                    ack_sel_m = sa;
                    ph        = SQ_R0;
                end
                default: ;
            endcase
        end else if (cv) begin
            n_dropped++;
        end
        // perform one step of the running sequence
        if (ph != SQ_IDLE) begin
            busy = 1'b1;
            case (ph)
                SQ_ST1: begin dir_in_m = 1'b0; sda_m = 1'b1; ph = SQ_ST2; end
                SQ_ST2: begin scl_m = 1'b1; ph = SQ_ST3; end
                SQ_ST3: begin sda_m = 1'b0; ph = SQ_ST4; end
                SQ_ST4: begin scl_m = 1'b0; ph = SQ_IDLE; done = 1'b1; end
                SQ_SP1: begin dir_in_m = 1'b0; scl_m = 1'b0; ph = SQ_SP2; end
                SQ_SP2: begin sda_m = 1'b0; ph = SQ_SP3; end
                SQ_SP3: begin scl_m = 1'b1; ph = SQ_SP4; end
                SQ_SP4: begin sda_m = 1'b1; ph = SQ_IDLE; done = 1'b1; end
                SQ_W0: begin
                    dir_in_m = 1'b0;
                    scl_m    = 1'b0;
                    bit_cnt  = '0;
                    ph       = SQ_W1;
                end
                SQ_W1: begin
                    sda_m   = shift_m[7];
                    shift_m = {shift_m[6:0], 1'b0};
                    ph      = SQ_W2;
                end
                SQ_W2: begin scl_m = 1'b1; ph = SQ_W3; end
                SQ_W3: begin scl_m = 1'b0; ph = SQ_W4; end
                SQ_W4: begin
                    if (bit_cnt == 3'd7) begin
                        wait_m = '0;
                        ph     = SQ_AKP;
                    end else begin
                        bit_cnt = bit_cnt + 3'd1;
                        ph      = SQ_W1;
                    end
                end
                // poll for the acknowledge; give up into a stop on timeout
                SQ_AKP: begin
                    dir_in_m = 1'b1;
                    sda_m    = 1'b1;
                    scl_m    = 1'b1;
                    if (!sd) begin
                        nack_m = 1'b0;
                        ph     = SQ_AKH;
                    end else if (wait_m >= timeout_m) begin
                        nack_m = 1'b1;
                        n_timeouts++;
                        ph     = SQ_SP1;
                    end else begin
                        wait_m = wait_m + 1'b1;
                    end
                end
                SQ_AKH: ph = SQ_AKL;
                SQ_AKL: begin scl_m = 1'b0; ph = SQ_AKT; end
                SQ_AKT: begin ph = SQ_IDLE; done = 1'b1; end
                SQ_R0: begin
                    dir_in_m = 1'b1;
                    sda_m    = 1'b1;
                    bit_cnt  = '0;
                    ph       = SQ_R1;
                end
                SQ_R1: begin scl_m = 1'b0; ph = SQ_R2; end
                SQ_R2: begin scl_m = 1'b1; ph = SQ_R3; end
                SQ_R3: begin
                    shift_m = {shift_m[6:0], sd};
                    if (bit_cnt == 3'd7) begin
                        ph = SQ_RA1;
                    end else begin
                        bit_cnt = bit_cnt + 3'd1;
                        ph      = SQ_R1;
                    end
                end
                SQ_RA1: begin
                    scl_m    = 1'b0;
                    dir_in_m = 1'b0;
                    rx_m     = shift_m;
                    ph       = SQ_RA2;
                end
                SQ_RA2: begin sda_m = ack_sel_m ? 1'b0 : 1'b1; ph = SQ_RA3; end
                SQ_RA3: begin scl_m = 1'b1; ph = SQ_RA4; end
                SQ_RA4: begin scl_m = 1'b0; ph = SQ_IDLE; done = 1'b1; end
                default: ph = SQ_IDLE;
            endcase
        end
        r.scl          = scl_m;
        r.sda_out      = dir_in_m ? 1'b1 : sda_m;
        r.sda_released = dir_in_m;
        r.busy_res     = busy;
        r.done_res     = done;
        r.rx_byte      = rx_m;
        r.nack         = nack_m;
        return r;
    endfunction

    // Choose the SDA level for the next tick: read pattern, delayed ACK or noise
    function automatic logic pick_sda(logic [7:0] rd_pat, int ack_highs);
        if (ph == SQ_R3)
            return rd_pat[3'd7 - bit_cnt];
        if (ph == SQ_AKP)
            return (ack_highs < 0 || int'(wait_m) < ack_highs) ? 1'b1 : 1'b0;
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int field_diff(string nm, logic [7:0] w, logic [7:0] g);
        if (g !== w) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, w, g);
            return 1;
        end
        return 0;
    endfunction

    // Offer one tick in bursts with random gaps; predict it once accepted
    task automatic send_tick(logic cv, logic [1:0] c, logic [7:0] tx, logic sa, logic sd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= {c, cv};
        s_tdata  <= {6'b0, sd, sa, tx};
        do @(posedge aclk); while (!s_tready);
        want_levels.push_back(bus_tick(cv, c, tx, sa, sd));
        n_ticks++;
    endtask

    // Issue one command and clock it through to the end
    task automatic do_cmd(logic [1:0] c, logic [7:0] tx, logic sa, logic [7:0] rd_pat,
                          int ack_highs, bit offer_more);
        send_tick(1'b1, c, tx, sa, 1'($urandom_range(0, 1)));
        while (ph != SQ_IDLE)
            send_tick(offer_more, 2'($urandom_range(0, 3)), 8'($urandom),
                      1'($urandom_range(0, 1)), pick_sda(rd_pat, ack_highs));
    endtask

    // Finish the running command, drain all results, then write the timeout
    task automatic set_timeout(logic [TIMEOUT_WIDTH-1:0] v);
        while (ph != SQ_IDLE)
            send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom),
                      1'($urandom_range(0, 1)), pick_sda(8'h00, 0));
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (want_levels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_m = v;
        n_cfg++;
    endtask

    task automatic run_random(int count, int high_pct);
        logic       cv;
        logic [1:0] c;
        logic       sd;
        repeat (count) begin
            // mostly commands when idle, occasional dropped ones while busy
            if (ph == SQ_IDLE)
                cv = ($urandom_range(0, 9) != 0);
            else
                cv = ($urandom_range(0, 19) == 0);
            c = 2'($urandom_range(0, 3));
            if (ph == SQ_AKP)
                sd = ($urandom_range(0, 99) < high_pct);
            else
                sd = 1'($urandom_range(0, 1));
            send_tick(cv, c, 8'($urandom), 1'($urandom_range(0, 1)), sd);
        end
    endtask

    task automatic test_idle_after_reset();
        repeat (4)
            send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_start_stop();
        do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 0, 1'b0);
        do_cmd(CMD_STOP, 8'hFF, 1'b1, 8'h00, 0, 1'b0);
    endtask

    task automatic test_write_bytes();
        do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 0, 1'b0);
        do_cmd(CMD_WRITE, 8'hFF, 1'b0, 8'h00, 0, 1'b0);
        do_cmd(CMD_WRITE, 8'h00, 1'b1, 8'h00, 5, 1'b0);
        do_cmd(CMD_WRITE, 8'hA5, 1'b0, 8'h00, 1, 1'b0);
        do_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 0, 1'b0);
    endtask

    task automatic test_read_bytes();
        do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 0, 1'b0);
        do_cmd(CMD_READ, 8'h00, 1'b1, 8'hFF, 0, 1'b0);
        do_cmd(CMD_READ, 8'hFF, 1'b0, 8'h00, 0, 1'b0);
        do_cmd(CMD_READ, 8'h3C, 1'b1, 8'h5A, 0, 1'b0);
        do_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 0, 1'b0);
    endtask

    // Commands offered during a sequence must be lost
    task automatic test_dropped_commands();
        do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 0, 1'b1);
        do_cmd(CMD_WRITE, 8'h96, 1'b0, 8'h00, 2, 1'b1);
        do_cmd(CMD_READ, 8'h00, 1'b0, 8'hC3, 0, 1'b1);
    endtask

    // Timeout at one, then a write that clears the flag again
    task automatic test_ack_timeout();
        set_timeout(16'd1);
        do_cmd(CMD_WRITE, 8'h55, 1'b0, 8'h00, -1, 1'b0);
        do_cmd(CMD_WRITE, 8'hAA, 1'b0, 8'h00, 1, 1'b0);
        do_cmd(CMD_WRITE, 8'h0F, 1'b0, 8'h00, 2, 1'b0);
    endtask

    task automatic test_zero_timeout();
        set_timeout(16'd0);
        do_cmd(CMD_WRITE, 8'h81, 1'b0, 8'h00, -1, 1'b0);
        do_cmd(CMD_WRITE, 8'h7E, 1'b0, 8'h00, 0, 1'b0);
    endtask

    // Long acknowledge wait at the widest timeout
    task automatic test_max_timeout();
        set_timeout(16'hFFFF);
        do_cmd(CMD_WRITE, 8'hF0, 1'b0, 8'h00, 24, 1'b0);
        do_cmd(CMD_WRITE, 8'h0F, 1'b0, 8'h00, 0, 1'b0);
    endtask

    task automatic test_random_traffic();
        set_timeout(16'd1);
        run_random(150, 60);
        set_timeout(16'd3);
        run_random(150, 70);
        steady = 1'b1;
        set_timeout(TIMEOUT_RESET);
        run_random(80, 50);
        steady = 1'b0;
        run_random(80, 50);
        set_timeout(16'hFFFF);
        run_random(150, 50);
        set_timeout(16'd0);
        run_random(100, 30);
        set_timeout(16'($urandom_range(1, 8)));
        run_random(100, 75);
    endtask

    // Receiver: alternate ready runs and stalls of random length
    always @(posedge aclk) begin
        if (steady || !aresetn) begin
            m_tready <= 1'b1;
        end else if (rx_run > 0) begin
            rx_run <= rx_run - 1;
        end else begin
            m_tready <= ~m_tready;
            rx_run   <= m_tready ? $urandom_range(0, 12) : $urandom_range(0, 30);
        end
    end

    // Compare each result transaction with the oldest predicted levels
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[13:0]);
            n_results++;
            if (want_levels.size() == 0) begin
                $display("%0t: result with nothing expected, expected none actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = want_levels.pop_front();
                errors += field_diff("scl", 8'(want.scl), 8'(got.scl));
                errors += field_diff("sda_out", 8'(want.sda_out), 8'(got.sda_out));
                errors += field_diff("sda_released", 8'(want.sda_released),
                                     8'(got.sda_released));
                errors += field_diff("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                errors += field_diff("done_res", 8'(want.done_res), 8'(got.done_res));
                errors += field_diff("rx_byte", want.rx_byte, got.rx_byte);
                errors += field_diff("nack", 8'(want.nack), 8'(got.nack));
            end
        end
    end

    // Stop the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles, %0d results pending",
                     $time, idle_cycles, want_levels.size());
            $display("[i2c_master_byte_engine] ERROR");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_after_reset();
        test_start_stop();
        test_write_bytes();
        test_read_bytes();
        test_dropped_commands();
        test_ack_timeout();
        test_zero_timeout();
        test_max_timeout();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (want_levels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("covered %0d ticks: %0d start, %0d stop, %0d write, %0d read, %0d dropped",
                 n_ticks, n_cmds[CMD_START], n_cmds[CMD_STOP], n_cmds[CMD_WRITE],
                 n_cmds[CMD_READ], n_dropped);
        $display("%0d ack timeouts over %0d timeout settings, %0d results, %0d mismatches",
                 n_timeouts, n_cfg, n_results, errors);
        if (errors == 0)
            $display("[i2c_master_byte_engine] OK");
        else
            $display("[i2c_master_byte_engine] ERROR");
        $finish;
    end

endmodule
